### hdl/htw_pkg.sv
`default_nettype none
package htw_pkg;

    localparam int OP_W   = 2;
    localparam int ID_W   = 6;
    localparam int EXP_W  = 32;
    localparam int TAG_W  = 16;
    localparam int KIND_W = 3;
    localparam int PTR_W  = 7;
    localparam int IN_W   = 56;
    localparam int OUT_W  = 24;

    localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
    localparam logic [OP_W-1:0] OP_DEL   = 2'd2;
    localparam logic [OP_W-1:0] OP_RESCH = 2'd3;

    localparam logic [KIND_W-1:0] KIND_IDLE        = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FIRED       = 3'd1;
    localparam logic [KIND_W-1:0] KIND_ACCEPT      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PENDING     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NOT_PENDING = 3'd4;

    localparam logic [PTR_W-1:0] NO_TIMER = 7'd127;

    typedef logic [2:0] t_cls;
    localparam t_cls CLS_TICK  = 3'd0;
    localparam t_cls CLS_BAD   = 3'd1;
    localparam t_cls CLS_DEL   = 3'd2;
    localparam t_cls CLS_ADD   = 3'd3;
    localparam t_cls CLS_RESCH = 3'd4;

    typedef struct packed {
        t_cls              cls;
        logic [ID_W-1:0]   id;
        logic [EXP_W-1:0]  expiry;
        logic [TAG_W-1:0]  tag;
    } t_req;

endpackage
`default_nettype wire

### hdl/htw_front.sv
`default_nettype none
module htw_front #(
    parameter int TIMERS = 64
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    output logic                     o_ready,
    input  wire  [htw_pkg::IN_W-1:0] i_data,
    output htw_pkg::t_req            o_req,
    output logic                     o_req_valid,
    input  wire                      i_req_ready
);
    import htw_pkg::*;

    localparam int QD = 4;
    localparam logic [PTR_W-1:0] TIM_LIM = PTR_W'(TIMERS);

    t_req             r_q [QD];
    logic [1:0]       r_wp, r_rp;
    logic [2:0]       r_cnt;
    logic [OP_W-1:0]  op;
    logic [ID_W-1:0]  id;
    t_cls             cls;
    t_req             req_in;
    logic             push, pop;

    assign op = i_data[1:0];
    assign id = i_data[7:2];

    // sort the item once so the back end only branches on a class
    always_comb begin
        cls = CLS_BAD;
        if (op == OP_TICK) begin
            cls = CLS_TICK;
        end else if ({1'b0, id} < TIM_LIM) begin
            unique case (op)
                OP_ADD:  cls = CLS_ADD;
                OP_DEL:  cls = CLS_DEL;
                default: cls = CLS_RESCH;
            endcase
        end
    end

    assign req_in = '{cls: cls, id: id, expiry: i_data[39:8], tag: i_data[55:40]};

    assign o_ready     = (r_cnt != 3'(QD));
    assign o_req_valid = (r_cnt != 3'd0);
    assign o_req       = r_q[r_rp];
    assign push        = i_valid & o_ready;
    assign pop         = o_req_valid & i_req_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= req_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 2'd1;
            if (pop)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(push) - 3'(pop);
        end
    end

endmodule
`default_nettype wire

### hdl/htw_div.sv
`default_nettype none
module htw_div #(
    parameter int DIVISOR = 1000
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_start,
    input  wire  [htw_pkg::EXP_W-1:0] i_dividend,
    output logic                      o_done,
    output logic [htw_pkg::EXP_W-1:0] o_quot
);
    import htw_pkg::*;

    localparam int HW = EXP_W / 2;
    localparam int MW = EXP_W + 1;
    localparam int PW = HW + MW;
    localparam int AW = 2 * EXP_W + 2;
    localparam int L  = $clog2(DIVISOR);
    localparam int SH = EXP_W + L;
    localparam logic [MW-1:0] RECIP = MW'(((64'd1 << SH) / 64'(DIVISOR)) + 64'd1);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_LO   = 2'd1;
    localparam logic [1:0] PH_HI   = 2'd2;

    logic [EXP_W-1:0] r_x;
    logic [AW-1:0]    r_acc;
    logic [1:0]       r_phase;
    logic             r_done;
    logic [HW-1:0]    half;
    logic [PW-1:0]    prod;

    // quotient by reciprocal multiplication, one half of the dividend per cycle
    assign half = (r_phase == PH_HI) ? r_x[EXP_W-1:HW] : r_x[HW-1:0];
    assign prod = {{MW{1'b0}}, half} * {{HW{1'b0}}, RECIP};

    assign o_done = r_done;
    assign o_quot = EXP_W'(r_acc >> SH);

    always_ff @(posedge i_clk) begin
        if (i_start) r_x <= i_dividend;
        if (r_phase == PH_LO) begin
            r_acc <= AW'(prod);
        end else if (r_phase == PH_HI) begin
            r_acc <= r_acc + {{(AW-PW-HW){1'b0}}, prod, {HW{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_phase == PH_HI);
            if (i_start) begin
                r_phase <= PH_LO;
            end else if (r_phase == PH_LO) begin
                r_phase <= PH_HI;
            end else begin
                r_phase <= PH_IDLE;
            end
        end
    end

endmodule
`default_nettype wire

### hdl/htw_back.sv
`default_nettype none
module htw_back #(
    parameter int SLOTS         = 16,
    parameter int TIMERS        = 64,
    parameter int RESOLUTION_US = 1000,
    parameter int TAG_BITS      = 16
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  htw_pkg::t_req              i_req,
    input  wire                        i_req_valid,
    output logic                       o_req_ready,
    output logic                       o_valid,
    input  wire                        i_ready,
    output logic [htw_pkg::KIND_W-1:0] o_kind,
    output logic [htw_pkg::ID_W-1:0]   o_id,
    output logic [htw_pkg::TAG_W-1:0]  o_tag,
    output logic                       o_last
);
    import htw_pkg::*;

    localparam int SW  = $clog2(SLOTS);
    localparam int TIW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int STW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
    localparam logic [SW-1:0]    SLOT_LAST = SW'(SLOTS - 1);
    localparam logic [SW:0]      SLOTS_S   = (SW+1)'(SLOTS);
    localparam logic [EXP_W-1:0] SLOTS_E   = EXP_W'(SLOTS);
    localparam logic [EXP_W-1:0] SPAN_E    = EXP_W'(SLOTS - 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIV   = 4'd1;
    localparam logic [3:0] S_THRD  = 4'd2;
    localparam logic [3:0] S_THEAD = 4'd3;
    localparam logic [3:0] S_URD   = 4'd4;
    localparam logic [3:0] S_UWR   = 4'd5;
    localparam logic [3:0] S_PCALC = 4'd6;
    localparam logic [3:0] S_PAPP  = 4'd7;
    localparam logic [3:0] S_PLINK = 4'd8;
    localparam logic [3:0] S_FIRE  = 4'd9;
    localparam logic [3:0] S_TEND  = 4'd10;
    localparam logic [3:0] S_EMIT  = 4'd11;

    // list stores
    logic [PTR_W-1:0] m_head  [SLOTS];
    logic [PTR_W-1:0] m_tail  [SLOTS];
    logic [PTR_W-1:0] m_next  [TIMERS];
    logic [PTR_W-1:0] m_prev  [TIMERS];
    logic [SW-1:0]    m_tslot [TIMERS];
    logic [EXP_W-1:0] m_rem   [TIMERS];
    logic [STW-1:0]   m_tag   [TIMERS];

    logic [PTR_W-1:0] r_head_q, r_tail_q, r_next_q, r_prev_q;
    logic [SW-1:0]    r_tslot_q;
    logic [EXP_W-1:0] r_rem_q;
    logic [STW-1:0]   r_tag_q;

    logic [3:0]        r_state;
    logic [SW-1:0]     r_cur, r_s;
    logic [PTR_W-1:0]  r_t;
    logic              r_tick;
    logic [EXP_W-1:0]  r_rem;
    logic [KIND_W-1:0] r_res_kind;
    logic [TIMERS-1:0] r_pend;
    logic [SLOTS-1:0]  r_head_vld, r_tail_vld;
    logic              r_hold_vld;
    logic [ID_W-1:0]   r_hold_id;
    logic [STW-1:0]    r_hold_tag, r_ftag;
    logic              r_out_vld, r_out_last;
    logic [KIND_W-1:0] r_out_kind;
    logic [ID_W-1:0]   r_out_id;
    logic [TAG_W-1:0]  r_out_tag;

    logic              can_emit, take, div_start, div_done, req_pend, big, emit;
    logic [EXP_W-1:0]  div_q, rem_new;
    logic [SW:0]       sum;
    logic [SW-1:0]     s_calc, cur_inc;
    logic [TIW-1:0]    t_idx, req_idx;

    logic we_next, we_prev, we_head, we_tail;
    logic [TIW-1:0]   wa_next, wa_prev;
    logic [SW-1:0]    wa_head, wa_tail;
    logic [PTR_W-1:0] wd_next, wd_prev, wd_head, wd_tail;

    assign can_emit    = !r_out_vld || i_ready;
    assign o_req_ready = (r_state == S_IDLE);
    assign take        = i_req_valid && o_req_ready;
    assign t_idx       = r_t[TIW-1:0];
    assign req_idx     = i_req.id[TIW-1:0];
    assign req_pend    = r_pend[req_idx];
    assign div_start   = take && (i_req.cls == CLS_ADD || i_req.cls == CLS_RESCH) && !req_pend;
    assign cur_inc     = (r_cur == SLOT_LAST) ? '0 : r_cur + SW'(1);
    assign emit        = can_emit && ((r_state == S_FIRE && r_hold_vld)
                                      || r_state == S_TEND || r_state == S_EMIT);

    htw_div #(.DIVISOR(RESOLUTION_US)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_req.expiry),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    // slot choice: long delays park one slot behind the current one
    always_comb begin
        big     = (r_rem >= SLOTS_E);
        sum     = {1'b0, r_cur} + {1'b0, r_rem[SW-1:0]};
        rem_new = big ? r_rem - SPAN_E : '0;
        if (big) begin
            s_calc = (r_cur == '0) ? SLOT_LAST : r_cur - SW'(1);
        end else if (sum >= SLOTS_S) begin
            s_calc = SW'(sum - SLOTS_S);
        end else begin
            s_calc = sum[SW-1:0];
        end
    end

    // link write ports
    always_comb begin
        we_next = 1'b0; wa_next = t_idx; wd_next = NO_TIMER;
        we_prev = 1'b0; wa_prev = t_idx; wd_prev = r_tail_q;
        we_head = 1'b0; wa_head = r_s;   wd_head = r_t;
        we_tail = 1'b0; wa_tail = r_s;   wd_tail = r_t;
        case (r_state)
            S_UWR: begin
                if (r_prev_q == NO_TIMER) begin
                    we_head = 1'b1; wa_head = r_tslot_q; wd_head = r_next_q;
                end else begin
                    we_next = 1'b1; wa_next = r_prev_q[TIW-1:0]; wd_next = r_next_q;
                end
                if (r_next_q == NO_TIMER) begin
                    we_tail = 1'b1; wa_tail = r_tslot_q; wd_tail = r_prev_q;
                end else begin
                    we_prev = 1'b1; wa_prev = r_next_q[TIW-1:0]; wd_prev = r_prev_q;
                end
            end
            S_PAPP: begin
                we_next = 1'b1;
                we_prev = 1'b1;
                we_tail = 1'b1;
                we_head = (r_tail_q == NO_TIMER);
            end
            S_PLINK: begin
                we_next = 1'b1; wa_next = r_tail_q[TIW-1:0]; wd_next = r_t;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_next) m_next[wa_next] <= wd_next;
        if (we_prev) m_prev[wa_prev] <= wd_prev;
        if (we_head) m_head[wa_head] <= wd_head;
        if (we_tail) m_tail[wa_tail] <= wd_tail;
        if (r_state == S_PAPP)  m_tslot[t_idx] <= r_s;
        if (r_state == S_PCALC) m_rem[t_idx]   <= rem_new;
        if (take && i_req.cls == CLS_ADD && !req_pend) begin
            m_tag[req_idx] <= i_req.tag[STW-1:0];
        end
        // registered reads, empty slots read as no timer
        r_head_q  <= r_head_vld[r_cur] ? m_head[r_cur] : NO_TIMER;
        r_tail_q  <= r_tail_vld[s_calc] ? m_tail[s_calc] : NO_TIMER;
        r_next_q  <= m_next[t_idx];
        r_prev_q  <= m_prev[t_idx];
        r_tslot_q <= m_tslot[t_idx];
        r_rem_q   <= m_rem[t_idx];
        r_tag_q   <= m_tag[t_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cur      <= '0;
            r_pend     <= '0;
            r_head_vld <= '0;
            r_tail_vld <= '0;
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_tick     <= 1'b0;
        end else begin
            if (we_head) r_head_vld[wa_head] <= 1'b1;
            if (we_tail) r_tail_vld[wa_tail] <= 1'b1;
            if (emit) r_out_vld <= 1'b1;
            else if (i_ready) r_out_vld <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_t    <= {1'b0, i_req.id};
                        r_tick <= (i_req.cls == CLS_TICK);
                        case (i_req.cls) inside
                            CLS_TICK: begin
                                r_cur   <= cur_inc;
                                r_state <= S_THRD;
                            end
                            CLS_DEL: begin
                                if (req_pend) begin
                                    r_state <= S_URD;
                                end else begin
                                    r_res_kind <= KIND_NOT_PENDING;
                                    r_state    <= S_EMIT;
                                end
                            end
                            CLS_ADD, CLS_RESCH: begin
                                if (req_pend) begin
                                    r_res_kind <= KIND_PENDING;
                                    r_state    <= S_EMIT;
                                end else begin
                                    r_state <= S_DIV;
                                end
                            end
                            default: begin
                                r_res_kind <= KIND_NOT_PENDING;
                                r_state    <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_rem   <= (div_q == '0) ? EXP_W'(1) : div_q;
                        r_state <= S_PCALC;
                    end
                end
                S_THRD: r_state <= S_THEAD;
                S_THEAD: begin
                    if (r_head_q != NO_TIMER) begin
                        r_t     <= r_head_q;
                        r_state <= S_URD;
                    end else begin
                        r_state <= S_TEND;
                    end
                end
                S_URD: r_state <= S_UWR;
                S_UWR: begin
                    r_rem  <= r_rem_q;
                    r_ftag <= r_tag_q;
                    if (!r_tick) begin
                        r_pend[t_idx] <= 1'b0;
                        r_res_kind    <= KIND_ACCEPT;
                        r_state       <= S_EMIT;
                    end else if (r_rem_q != '0) begin
                        r_state <= S_PCALC;
                    end else begin
                        r_state <= S_FIRE;
                    end
                end
                S_PCALC: begin
                    r_s     <= s_calc;
                    r_state <= S_PAPP;
                end
                S_PAPP, S_PLINK: begin
                    if (r_state == S_PAPP && r_tail_q != NO_TIMER) begin
                        r_state <= S_PLINK;
                    end else if (r_tick) begin
                        r_state <= S_THRD;
                    end else begin
                        r_pend[t_idx] <= 1'b1;
                        r_res_kind    <= KIND_ACCEPT;
                        r_state       <= S_EMIT;
                    end
                end
                S_FIRE: begin
                    // one fired timer is held back until we know whether it is the last
                    r_pend[t_idx] <= 1'b0;
                    if (!r_hold_vld || can_emit) begin
                        if (r_hold_vld) begin
                            r_out_kind <= KIND_FIRED;
                            r_out_id   <= r_hold_id;
                            r_out_tag  <= TAG_W'(r_hold_tag);
                            r_out_last <= 1'b0;
                        end
                        r_hold_vld <= 1'b1;
                        r_hold_id  <= r_t[ID_W-1:0];
                        r_hold_tag <= r_ftag;
                        r_state    <= S_THRD;
                    end
                end
                S_TEND: begin
                    if (can_emit) begin
                        r_out_kind <= r_hold_vld ? KIND_FIRED : KIND_IDLE;
                        r_out_id   <= r_hold_vld ? r_hold_id : '0;
                        r_out_tag  <= r_hold_vld ? TAG_W'(r_hold_tag) : '0;
                        r_out_last <= 1'b1;
                        r_hold_vld <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (can_emit) begin
                        r_out_kind <= r_res_kind;
                        r_out_id   <= r_t[ID_W-1:0];
                        r_out_tag  <= '0;
                        r_out_last <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_out_vld;
    assign o_kind  = r_out_kind;
    assign o_id    = r_out_id;
    assign o_tag   = r_out_tag;
    assign o_last  = r_out_last;

endmodule
`default_nettype wire

### hdl/hashed_timer_wheel.sv
`default_nettype none
// Hashed timing wheel with a pool of TIMERS timers on a ring of SLOTS slots. Requests
// (tick, add, delete, reschedule) enter a four-beat queue and are executed one at a
// time by a sequencer over list memories with registered reads. A rejected request
// goes straight to its result beat, and a delete of a pending timer first unlinks it.
// Add and reschedule pass through the reciprocal-multiply divider that turns microseconds
// into ticks, with an extra link step when the target slot already holds timers. A
// tick walks the next slot, firing or moving on each timer in it; it gives one beat
// per fired timer in walk order, or a single kind-0 beat, and tlast marks its final
// beat. Output stalls hold the sequencer. No clearing pass is needed after reset.
module hashed_timer_wheel #(
    parameter int SLOTS         = 16,
    parameter int TIMERS        = 64,
    parameter int RESOLUTION_US = 1000,
    parameter int TAG_BITS      = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // operation[1:0], timer_id[7:2], expiry_us[39:8], callback_tag[55:40]
    input  wire  [htw_pkg::IN_W-1:0]     i_s_axis_tdata,
    output logic                         o_m_axis_tvalid,
    input  wire                          i_m_axis_tready,
    // fired_id[5:0], fired_tag[21:6], zero fill
    output logic [htw_pkg::OUT_W-1:0]    o_m_axis_tdata,
    // kind[2:0]
    output logic [htw_pkg::KIND_W-1:0]   o_m_axis_tuser,
    output logic                         o_m_axis_tlast
);
    import htw_pkg::*;

    t_req              req;
    logic              req_valid, req_ready;
    logic [ID_W-1:0]   out_id;
    logic [TAG_W-1:0]  out_tag;

    htw_front #(.TIMERS(TIMERS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_data      (i_s_axis_tdata),
        .o_req       (req),
        .o_req_valid (req_valid),
        .i_req_ready (req_ready)
    );

    htw_back #(
        .SLOTS         (SLOTS),
        .TIMERS        (TIMERS),
        .RESOLUTION_US (RESOLUTION_US),
        .TAG_BITS      (TAG_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_kind      (o_m_axis_tuser),
        .o_id        (out_id),
        .o_tag       (out_tag),
        .o_last      (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {2'b00, out_tag, out_id};

`ifndef SYNTH
    // only a tick can give more than one beat, and those are all fired beats
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != KIND_FIRED |-> o_m_axis_tlast)
        else $error("non-fired beat without tlast");

    a_tag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != KIND_FIRED |-> o_m_axis_tdata[21:6] == 16'd0)
        else $error("tag on a non-fired beat");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == KIND_IDLE |-> o_m_axis_tdata == '0)
        else $error("empty tick beat carries data");
`endif

endmodule
`default_nettype wire

### bench/hashed_timer_wheel_test.sv
`default_nettype none
module hashed_timer_wheel_test;
    timeunit 1ns;
    timeprecision 1ps;

    import htw_pkg::*;

    localparam int NSLOT  = 16;
    localparam int NTIMER = 64;
    localparam int TICK_US = 1000;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic [TAG_W-1:0]  tag;
        logic              last;
    } t_wheel_beat;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_axis_tvalid;
    logic              o_s_axis_tready;
    logic [IN_W-1:0]   i_s_axis_tdata;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  o_m_axis_tdata;
    logic [KIND_W-1:0] o_m_axis_tuser;
    logic              o_m_axis_tlast;

    hashed_timer_wheel u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // shadow of the wheel
    int unsigned      cur_slot;
    logic [PTR_W-1:0] head_of[NSLOT];
    logic [PTR_W-1:0] tail_of[NSLOT];
    logic [PTR_W-1:0] next_of[NTIMER];
    logic [PTR_W-1:0] prev_of[NTIMER];
    int unsigned      ticks_left[NTIMER];
    logic [TAG_W-1:0] tag_of[NTIMER];
    bit               armed[NTIMER];
    bit               tag_known[NTIMER];
    int unsigned      slot_of[NTIMER];

    t_wheel_beat expected_beats[$];
    bit          failed;
    int          burst_left;
    int          fired_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("hashed_timer_wheel: mismatch");
        $finish;
    end

    function automatic void unlink(int unsigned t);
        int unsigned s;
        s = slot_of[t];
        if (prev_of[t] == NO_TIMER) head_of[s] = next_of[t];
        else next_of[prev_of[t]] = next_of[t];
        if (next_of[t] == NO_TIMER) tail_of[s] = prev_of[t];
        else prev_of[next_of[t]] = prev_of[t];
    endfunction

    function automatic void place(int unsigned t);
        int unsigned s;
        if (ticks_left[t] >= NSLOT) begin
            s = (cur_slot + NSLOT - 1) % NSLOT;
            ticks_left[t] = ticks_left[t] - (NSLOT - 1);
        end else begin
            s = (cur_slot + ticks_left[t]) % NSLOT;
            ticks_left[t] = 0;
        end
        slot_of[t] = s;
        next_of[t] = NO_TIMER;
        prev_of[t] = tail_of[s];
        if (tail_of[s] == NO_TIMER) head_of[s] = PTR_W'(t);
        else next_of[tail_of[s]] = PTR_W'(t);
        tail_of[s] = PTR_W'(t);
    endfunction

    function automatic void push_beat(logic [KIND_W-1:0] k, logic [ID_W-1:0] id,
                                      logic [TAG_W-1:0] tg, logic lst);
        t_wheel_beat b;
        b.kind = k;
        b.id   = id;
        b.tag  = tg;
        b.last = lst;
        expected_beats.push_back(b);
    endfunction

    function automatic void predict_wheel(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                          logic [EXP_W-1:0] dly, logic [TAG_W-1:0] tg);
        int unsigned t;
        int unsigned n;
        int unsigned ticks;
        n = 0;
        if (op == OP_TICK) begin
            cur_slot = (cur_slot + 1) % NSLOT;
            while (head_of[cur_slot] != NO_TIMER) begin
                t = head_of[cur_slot];
                unlink(t);
                if (ticks_left[t] > 0) begin
                    place(t);
                end else begin
                    armed[t] = 1'b0;
                    push_beat(KIND_FIRED, ID_W'(t), tag_of[t], 1'b0);
                    n++;
                end
            end
            if (n == 0) push_beat(KIND_IDLE, '0, '0, 1'b0);
            expected_beats[$].last = 1'b1;
            fired_count += n;
        end else if (op == OP_DEL) begin
            if (armed[id]) begin
                unlink(id);
                armed[id] = 1'b0;
                push_beat(KIND_ACCEPT, id, '0, 1'b1);
            end else begin
                push_beat(KIND_NOT_PENDING, id, '0, 1'b1);
            end
        end else if (armed[id]) begin
            push_beat(KIND_PENDING, id, '0, 1'b1);
        end else begin
            ticks = dly / TICK_US;
            if (ticks == 0) ticks = 1;
            if (op == OP_ADD) begin
                tag_of[id] = tg;
                tag_known[id] = 1'b1;
            end
            ticks_left[id] = ticks;
            place(id);
            armed[id] = 1'b1;
            push_beat(KIND_ACCEPT, id, '0, 1'b1);
        end
    endfunction

    // one request beat; valid stays up across a burst
    task automatic send_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                logic [EXP_W-1:0] dly, logic [TAG_W-1:0] tg);
        int gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {tg, dly, id, op};
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_wheel(op, id, dly, tg);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // receiver stall pattern: phases of always-ready and of random stalls
    int unsigned stall_phase = 0;
    int unsigned stall_mode = 0;
    always @(posedge i_clk) begin
        if (stall_phase == 0) begin
            stall_phase <= $urandom_range(10, 80);
            stall_mode  <= $urandom_range(0, 2);
        end else begin
            stall_phase <= stall_phase - 1;
        end
        case (stall_mode)
            0: i_m_axis_tready <= 1'b1;
            1: i_m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_wheel_beat e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected beat kind %0d id %0d tag %h last %b", $realtime,
                         o_m_axis_tuser, o_m_axis_tdata[5:0], o_m_axis_tdata[21:6],
                         o_m_axis_tlast);
                failed = 1'b1;
            end else begin
                e = expected_beats.pop_front();
                if (o_m_axis_tuser !== e.kind || o_m_axis_tdata[5:0] !== e.id
                    || o_m_axis_tdata[21:6] !== e.tag || o_m_axis_tdata[23:22] !== 2'b00
                    || o_m_axis_tlast !== e.last) begin
                    $display({"%0t: expected kind %0d id %0d tag %h last %b, ",
                              "got kind %0d id %0d tag %h last %b fill %b"},
                             $realtime, e.kind, e.id, e.tag, e.last, o_m_axis_tuser,
                             o_m_axis_tdata[5:0], o_m_axis_tdata[21:6], o_m_axis_tlast,
                             o_m_axis_tdata[23:22]);
                    failed = 1'b1;
                end
            end
        end
    end

    task automatic test_requests();
        send_request(OP_ADD, 6'd0, 32'd0, 16'hFFFF);
        send_request(OP_ADD, 6'd0, 32'd5000, 16'h1234);
        send_request(OP_RESCH, 6'd0, 32'd5000, 16'h0);
        send_request(OP_TICK, 6'd0, 32'd0, 16'h0);
        send_request(OP_DEL, 6'd0, 32'd0, 16'h0);
        send_request(OP_RESCH, 6'd0, 32'd2000, 16'hFFFF);
        send_request(OP_ADD, 6'd63, 32'd999, 16'h0000);
        send_request(OP_ADD, 6'd1, 32'd1000, 16'hAAAA);
        send_request(OP_ADD, 6'd2, 32'd1500, 16'h5555);
    endtask

    task automatic test_extremes();
        send_request(OP_ADD, 6'd5, 32'd15999, 16'hA5A5);
        send_request(OP_ADD, 6'd6, 32'd16000, 16'h5A5A);
        send_request(OP_ADD, 6'd7, 32'hFFFF_FFFF, 16'h0001);
        send_request(OP_DEL, 6'd7, 32'hFFFF_FFFF, 16'hFFFF);
        // several fire on the first tick, one on the next, the rest walk an empty slot
        repeat (6) send_request(OP_TICK, 6'h3F, 32'hFFFF_FFFF, 16'hFFFF);
        send_request(OP_DEL, 6'd5, 32'd0, 16'h0);
        send_request(OP_DEL, 6'd6, 32'd0, 16'h0);
        send_request(OP_DEL, 6'd6, 32'd0, 16'h0);
    endtask

    task automatic test_random();
        int unsigned i;
        int unsigned r;
        logic [OP_W-1:0] op;
        logic [ID_W-1:0] id;
        logic [EXP_W-1:0] dly;
        i = 0;
        while (i < 140) begin
            if (i == 70) wait_drained();
            r = $urandom_range(0, 99);
            id = ($urandom_range(0, 3) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, 15));
            if (r < 40) op = OP_TICK;
            else if (r < 75) op = OP_ADD;
            else if (r < 90) op = OP_DEL;
            else op = OP_RESCH;
            if (op == OP_RESCH && !tag_known[id]) op = OP_ADD;
            r = $urandom_range(0, 99);
            if (r < 70) dly = $urandom_range(0, 20000);
            else if (r < 92) dly = $urandom_range(0, 100000);
            else dly = $urandom;
            send_request(op, id, dly, TAG_W'($urandom));
            i++;
        end
    endtask

    initial begin
        failed = 1'b0;
        fired_count = 0;
        burst_left = 0;
        cur_slot = 0;
        for (int s = 0; s < NSLOT; s++) begin
            head_of[s] = NO_TIMER;
            tail_of[s] = NO_TIMER;
        end
        for (int t = 0; t < NTIMER; t++) begin
            next_of[t] = '0;
            prev_of[t] = '0;
            ticks_left[t] = 0;
            tag_of[t] = '0;
            armed[t] = 1'b0;
            tag_known[t] = 1'b0;
            slot_of[t] = 0;
        end
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_requests();
        test_extremes();
        wait_drained();
        test_random();
        wait_drained();
        if (!failed && expected_beats.size() == 0) begin
            $display("hashed_timer_wheel: match");
        end else begin
            $display("hashed_timer_wheel: mismatch");
        end
        $finish;
    end

endmodule
`default_nettype wire
